FILE: rtl/core/can_motor_command_gate_assert.svh
// ----------------------------------------------------------------------------
// can_motor_command_gate_assert.svh
// assertion macros shared by the checker of the motor command gate
// ----------------------------------------------------------------------------
`ifndef CAN_MOTOR_COMMAND_GATE_ASSERT_SVH
`define CAN_MOTOR_COMMAND_GATE_ASSERT_SVH

// property checked at every clock edge outside reset
`define CMG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every clock edge, reset included
`define CMG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/cmg_pkg.sv
// ----------------------------------------------------------------------------
// cmg_pkg
// types, codes and constants of the motor command gate
// ----------------------------------------------------------------------------
package cmg_pkg;

  // port widths
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // item kinds on the input tuser
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RPM    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ID    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SECTION    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GLOBAL_ID  = 3'd4;

  // accepted frame kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_GLOBAL = 2'd1;
  localparam logic [1:0] KIND_NODE   = 2'd2;

  // register reset values
  localparam logic [15:0] TIMEOUT_RST   = 16'd300;
  localparam logic [11:0] MAX_RPM_RST   = 12'd120;
  localparam logic [5:0]  NODE_ID_RST   = 6'd1;
  localparam logic [3:0]  SECTION_RST   = 4'd0;
  localparam logic [10:0] GLOBAL_ID_RST = 11'd128;

  // frame constants
  localparam logic [10:0] NODE_BASE_ID = 11'h100;
  localparam logic [3:0]  FULL_LENGTH  = 4'd8;
  localparam logic [16:0] AGE_MAX      = 17'h1FFFF;

  // command codes and flag bits
  localparam logic [7:0] CMD_RUN        = 8'd1;
  localparam logic [7:0] CMD_PHASE_LO   = 8'd3;
  localparam logic [7:0] CMD_PHASE_HI   = 8'd5;
  localparam int         FLAG_DRIVE_EN  = 0;
  localparam int         FLAG_ESTOP     = 2;
  localparam int         FLAG_CLOSED    = 3;
  localparam int         NFLAG_ENABLE   = 0;

  // divide by ten: (n * 52429) >> 19 is exact for n below 43690
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  // rpm to 1/256 rad/s, scaled by 1024
  localparam logic [14:0] VEL_CLOSED_MUL = 15'd27451;
  localparam logic [14:0] VEL_OPEN_MUL   = 15'd9883;

  // output tdata bit positions
  localparam int OD_RUN   = 0;
  localparam int OD_SEC   = 1;
  localparam int OD_OPEN  = 2;
  localparam int OD_GFR   = 3;
  localparam int OD_NFR   = 4;
  localparam int OD_PHASE = 5;
  localparam int OD_RPM   = 7;
  localparam int OD_VEL   = 19;

  // per-request status worked out by the front
  typedef struct packed {
    logic [1:0] kind;
    logic       run;
    logic       sec_active;
    logic       open_loop;
    logic       g_fresh;
    logic       n_fresh;
    logic [1:0] phase;
  } cmg_flags_t;

  // queue entry: status plus speed operands
  typedef struct packed {
    cmg_flags_t  flags;
    logic [15:0] base_speed;
    logic [15:0] trim;
  } cmg_entry_t;

endpackage

FILE: rtl/core/cmg_front.sv
// ----------------------------------------------------------------------------
// cmg_front
// takes frames and ticks, holds the latched frame state and ages, and
// classifies each request into a queue entry
// ----------------------------------------------------------------------------
module cmg_front
  import cmg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tuser,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [11:0]            max_rpm,
  input  logic                   q_full,
  output logic                   q_push,
  output cmg_entry_t             q_entry
);

  // configuration registers
  logic [15:0] timeout_r;
  logic [11:0] max_rpm_r;
  logic [5:0]  node_id_r;
  logic [3:0]  section_r;
  logic [10:0] global_id_r;

  // latched frame state
  logic [7:0]  ctrl_flags_r, ctrl_flags_nxt;
  logic [15:0] base_r,       base_nxt;
  logic [7:0]  cmd_r,        cmd_nxt;
  logic [7:0]  nflags_r,     nflags_nxt;
  logic [15:0] trim_r,       trim_nxt;
  logic [15:0] sect_bits_r,  sect_bits_nxt;
  logic [16:0] g_age_r,      g_age_nxt;
  logic [16:0] n_age_r,      n_age_nxt;

  // request fields
  logic [10:0] fid;
  logic        ext;
  logic [3:0]  dlen;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [15:0] w2;
  logic [15:0] w4;

  logic        accept;
  logic        is_frame;
  logic        hit_g;
  logic        hit_n;
  logic [10:0] node_fid;
  logic [1:0]  kind;
  logic        g_fresh;
  logic        n_fresh;
  logic        phase_cmd;
  logic        cmd_en;
  logic        sec_active;
  logic        run;
  logic [7:0]  phase_sel;

  assign fid  = in_tdata[10:0];
  assign ext  = in_tdata[11];
  assign dlen = in_tdata[15:12];
  assign b0   = in_tdata[23:16];
  assign b1   = in_tdata[31:24];
  assign w2   = in_tdata[47:32];
  assign w4   = in_tdata[63:48];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign max_rpm   = max_rpm_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      max_rpm_r   <= MAX_RPM_RST;
      node_id_r   <= NODE_ID_RST;
      section_r   <= SECTION_RST;
      global_id_r <= GLOBAL_ID_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIMEOUT:   timeout_r   <= cfg_data;
        REG_MAX_RPM:   max_rpm_r   <= cfg_data[11:0];
        REG_NODE_ID:   node_id_r   <= cfg_data[5:0];
        REG_SECTION:   section_r   <= cfg_data[3:0];
        REG_GLOBAL_ID: global_id_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // frame match
  assign node_fid = NODE_BASE_ID + {5'd0, node_id_r};
  assign is_frame = (in_tuser == OP_FRAME) && !ext && (dlen == FULL_LENGTH);
  assign hit_g    = is_frame && (fid == global_id_r);
  assign hit_n    = is_frame && !hit_g && (fid == node_fid);

  // state update
  always_comb begin
    ctrl_flags_nxt = ctrl_flags_r;
    base_nxt       = base_r;
    cmd_nxt        = cmd_r;
    nflags_nxt     = nflags_r;
    trim_nxt       = trim_r;
    sect_bits_nxt  = sect_bits_r;
    g_age_nxt      = g_age_r;
    n_age_nxt      = n_age_r;
    kind           = KIND_NONE;
    if (in_tuser == OP_TICK) begin
      g_age_nxt = (g_age_r == AGE_MAX) ? AGE_MAX : g_age_r + 17'd1;
      n_age_nxt = (n_age_r == AGE_MAX) ? AGE_MAX : n_age_r + 17'd1;
    end else if (hit_g) begin
      ctrl_flags_nxt = b1;
      base_nxt       = w2;
      g_age_nxt      = '0;
      kind           = KIND_GLOBAL;
    end else if (hit_n) begin
      cmd_nxt       = b0;
      nflags_nxt    = b1;
      trim_nxt      = w2;
      sect_bits_nxt = w4;
      n_age_nxt     = '0;
      kind          = KIND_NODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_flags_r <= '0;
      base_r       <= '0;
      cmd_r        <= '0;
      nflags_r     <= '0;
      trim_r       <= '0;
      sect_bits_r  <= '0;
      g_age_r      <= AGE_MAX;
      n_age_r      <= AGE_MAX;
    end else if (accept) begin
      ctrl_flags_r <= ctrl_flags_nxt;
      base_r       <= base_nxt;
      cmd_r        <= cmd_nxt;
      nflags_r     <= nflags_nxt;
      trim_r       <= trim_nxt;
      sect_bits_r  <= sect_bits_nxt;
      g_age_r      <= g_age_nxt;
      n_age_r      <= n_age_nxt;
    end
  end

  // run permission from the updated state
  assign g_fresh    = g_age_nxt <= {1'b0, timeout_r};
  assign n_fresh    = n_age_nxt <= {1'b0, timeout_r};
  assign phase_cmd  = (cmd_nxt >= CMD_PHASE_LO) && (cmd_nxt <= CMD_PHASE_HI);
  assign cmd_en     = !n_fresh || (cmd_nxt == CMD_RUN) || nflags_nxt[NFLAG_ENABLE]
                      || (n_fresh && phase_cmd);
  assign sec_active = !n_fresh || sect_bits_nxt[section_r];
  assign run        = g_fresh && ctrl_flags_nxt[FLAG_DRIVE_EN]
                      && !ctrl_flags_nxt[FLAG_ESTOP] && cmd_en && sec_active;
  assign phase_sel  = cmd_nxt - 8'd2;

  // queue entry
  always_comb begin
    q_entry.flags.kind       = kind;
    q_entry.flags.run        = run;
    q_entry.flags.sec_active = sec_active;
    q_entry.flags.open_loop  = !ctrl_flags_nxt[FLAG_CLOSED];
    q_entry.flags.g_fresh    = g_fresh;
    q_entry.flags.n_fresh    = n_fresh;
    q_entry.flags.phase      = (run && phase_cmd) ? phase_sel[1:0] : 2'd0;
    q_entry.base_speed       = base_nxt;
    q_entry.trim             = trim_nxt;
  end

  assign q_push = accept;

endmodule

FILE: rtl/core/cmg_queue.sv
// ----------------------------------------------------------------------------
// cmg_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module cmg_queue
  import cmg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmg_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       avail,
  output cmg_entry_t pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  cmg_entry_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_FULL);
  assign avail     = (count_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && avail;

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_ONE;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/core/cmg_back.sv
// ----------------------------------------------------------------------------
// cmg_back
// three-stage speed pipeline: trim divide, clamp, velocity scale; drives
// the result channel
// ----------------------------------------------------------------------------
module cmg_back
  import cmg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [11:0]           max_rpm,
  input  logic                  q_avail,
  input  cmg_entry_t            q_entry,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  // stage valids
  logic a_valid_r;
  logic b_valid_r;
  logic c_valid_r;
  logic adv_a;
  logic adv_b;
  logic adv_c;

  // stage a: trim magnitude divided by ten
  cmg_flags_t  a_flags_r;
  logic [15:0] a_base_r;
  logic        a_neg_r;
  logic [11:0] a_quot_r;
  logic [16:0] trim_abs;
  logic [33:0] div_prod;

  // stage b: clamped rpm
  cmg_flags_t  b_flags_r;
  logic [11:0] b_rpm_r;
  logic signed [17:0] delta;
  logic signed [17:0] req;
  logic [11:0] rpm_clamp;

  // stage c: output register
  cmg_flags_t  c_flags_r;
  logic [11:0] c_rpm_r;
  logic [16:0] c_vel_r;
  logic [14:0] vel_mul;
  logic [26:0] vel_prod;

  // pipeline advance, stalled from the result side
  assign adv_c = !c_valid_r || out_tready;
  assign adv_b = !b_valid_r || adv_c;
  assign adv_a = !a_valid_r || adv_b;
  assign q_pop = q_avail && adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_r <= q_avail;
      end
      if (adv_b) begin
        b_valid_r <= a_valid_r;
      end
      if (adv_c) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  // stage a
  assign trim_abs = q_entry.trim[15] ? 17'd0 - {1'b1, q_entry.trim}
                                     : {1'b0, q_entry.trim};
  assign div_prod = 34'(trim_abs) * 34'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_flags_r <= q_entry.flags;
      a_base_r  <= q_entry.base_speed;
      a_neg_r   <= q_entry.trim[15];
      a_quot_r  <= div_prod[DIV10_SHIFT +: 12];
    end
  end

  // stage b: base plus trim, clamped to 0..max_rpm
  assign delta = a_neg_r ? -$signed({6'd0, a_quot_r}) : $signed({6'd0, a_quot_r});
  assign req   = $signed({2'd0, a_base_r}) + delta;

  always_comb begin
    if (req <= 18'sd0) begin
      rpm_clamp = '0;
    end else if (req >= $signed({6'd0, max_rpm})) begin
      rpm_clamp = max_rpm;
    end else begin
      rpm_clamp = req[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_flags_r <= a_flags_r;
      b_rpm_r   <= a_flags_r.run ? rpm_clamp : 12'd0;
    end
  end

  // stage c: velocity scale
  assign vel_mul  = b_flags_r.open_loop ? VEL_OPEN_MUL : VEL_CLOSED_MUL;
  assign vel_prod = 27'(b_rpm_r) * 27'(vel_mul);

  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_flags_r <= b_flags_r;
      c_rpm_r   <= b_rpm_r;
      c_vel_r   <= vel_prod[26:10];
    end
  end

  // result channel
  assign out_tvalid = c_valid_r;
  assign out_tuser  = c_flags_r.kind;

  always_comb begin
    out_tdata                  = '0;
    out_tdata[OD_RUN]          = c_flags_r.run;
    out_tdata[OD_SEC]          = c_flags_r.sec_active;
    out_tdata[OD_OPEN]         = c_flags_r.open_loop;
    out_tdata[OD_GFR]          = c_flags_r.g_fresh;
    out_tdata[OD_NFR]          = c_flags_r.n_fresh;
    out_tdata[OD_PHASE +: 2]   = c_flags_r.phase;
    out_tdata[OD_RPM +: 12]    = c_rpm_r;
    out_tdata[OD_VEL +: 17]    = c_vel_r;
  end

endmodule

FILE: rtl/core/can_motor_command_gate.sv
// ----------------------------------------------------------------------------
// can_motor_command_gate
// CAN command gate: latches control frames, ages them on ticks and derives
// run permission and target speed for one motor node
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake, a received frame (in_tuser = 0) or a
//           millisecond tick (in_tuser = 1), frame fields in in_tdata.
//   out_* : exactly one result per request, in order; the latched kind in
//           out_tuser, status and target speed in out_tdata.
//   cfg_* : register writes (index, data), always ready; write only while
//           no request is in flight.
//   One request per cycle is taken and delivered steadily while the receiver
//   does not stall, set by the state update in the front and the three-stage
//   speed pipeline in the back.
//   A queue of DEPTH entries (QUEUE_DEPTH by default) sits between the two; when the receiver
//   stalls the pipeline holds, the queue fills and in_tready falls once it
//   is full.
//   Reset (rst_n low, synchronous) restores register defaults, clears the
//   latched frames, marks both frames stale and empties queue and pipeline.
// ----------------------------------------------------------------------------
module can_motor_command_gate
  import cmg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // frame_id[10:0], extended_id[11], data_length[15:12], byte_zero[23:16],
  // byte_one[31:24], word_two[47:32], word_four[63:48]
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // op[0]
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // run_ok[0], sec_on[1], open_loop[2], glob_live[3], node_live[4],
  // phase_test[6:5], rpm_goal[18:7], vel_goal[35:19], zero[39:36]
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // accepted_kind[1:0]
  output logic [OUT_USER_W-1:0]  out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_avail;
  cmg_entry_t  push_entry;
  cmg_entry_t  pop_entry;
  logic [11:0] max_rpm;

  assign cfg_ready = 1'b1;

  // request front
  cmg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .max_rpm   (max_rpm),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  // queue between front and back
  cmg_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .avail      (q_avail),
    .pop_entry  (pop_entry)
  );

  // speed pipeline and result channel
  cmg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_rpm    (max_rpm),
    .q_avail    (q_avail),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/core/cmg_checker.sv
// ----------------------------------------------------------------------------
// cmg_port_checker
// port-level checks of the motor command gate, bound to the top level
// ----------------------------------------------------------------------------
`include "can_motor_command_gate_assert.svh"

module cmg_port_checker
  import cmg_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  logic [OUT_USER_W+OUT_DATA_W-1:0] beat;
  logic                             stalled;
  logic                             idle;
  logic                             speed_zero;
  logic                             stale;
  logic                             kind_ok;

  // result word and the conditions the checks look at
  assign beat       = {out_tuser, out_tdata};
  assign stalled    = out_tvalid && !out_tready;
  assign idle       = out_tvalid && !out_tdata[OD_RUN];
  assign speed_zero = (out_tdata[OD_PHASE +: 2] == 2'd0) && (out_tdata[OD_RPM +: 12] == 12'd0)
                      && (out_tdata[OD_VEL +: 17] == 17'd0);
  assign stale      = out_tvalid && !out_tdata[OD_NFR];
  assign kind_ok    = (out_tuser == KIND_NONE) || (out_tuser == KIND_GLOBAL)
                      || (out_tuser == KIND_NODE);

  // stalled result holds
  `CMG_ASSERT(a_out_hold, stalled |=> out_tvalid && $stable(beat), "result changed while stalled")

  // no result right after reset
  `CMG_ASSERT_ALWAYS(a_rst_empty, !$past(rst_n) |-> !out_tvalid, "result valid after reset")

  // speed and phase are zero unless running
  `CMG_ASSERT(a_idle_zero, idle |-> speed_zero, "speed set while not running")

  // a stale node frame leaves the section active
  `CMG_ASSERT(a_stale_sec, stale |-> out_tdata[OD_SEC], "section inactive on stale node frame")

  // kind code is never the unused value
  `CMG_ASSERT(a_kind_code, out_tvalid |-> kind_ok, "bad accepted kind")

endmodule

bind can_motor_command_gate cmg_port_checker u_cmg_checker (.*);
